>>> rtl/core/escaped_text_attribute_decoder_unit_defines.svh
// Assertion macros for the checker of the decoder.
`ifndef ESCAPED_TEXT_ATTRIBUTE_DECODER_UNIT_DEFINES_SVH
`define ESCAPED_TEXT_ATTRIBUTE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ETAD_ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("etad: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define ETAD_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("etad: next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define ETAD_ASSERT_NEXT_ALWAYS(label, clk, a, c) \
	label: assert property (@(posedge clk) (a) |=> (c)) \
		else $error("etad: reset check failed");

`endif

>>> rtl/core/etad_pkg.sv
package etad_pkg;

	localparam int OP_DEPTH_DEF  = 4;
	localparam int OUT_DEPTH_DEF = 2;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_in;
	} in_t;

	typedef struct packed {
		logic [7:0] glyph_code;
		logic       glyph_font;
		logic [1:0] glyph_level;
		logic       glyph_back;
		logic       glyph_bar;
		logic       line_end;
	} out_t;

	typedef struct packed {
		logic       bar;
		logic       back;
		logic [1:0] level;
		logic       font;
		logic [7:0] code;
	} glyph_t;

	// One transaction from the front part to the back part.
	typedef struct packed {
		logic   is_glyph;
		logic   last;
		glyph_t glyph;
	} op_t;

endpackage

>>> rtl/core/etad_fifo.sv
module etad_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  T     wdata,
	input  logic rd,
	output T     rdata,
	output logic full,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	T              mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/etad_front.sv
module etad_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  etad_pkg::in_t  item,
	input  logic           op_full,
	output logic           accept,
	output logic           op_push,
	output etad_pkg::op_t  op
);
	import etad_pkg::*;

	localparam logic [1:0] FONT_LATIN   = 2'd0;
	localparam logic [1:0] FONT_GREEK   = 2'd1;
	localparam logic [1:0] FONT_SPECIAL = 2'd2;

	localparam logic [1:0] LEVEL_NORMAL = 2'd0;
	localparam logic [1:0] LEVEL_UP     = 2'd1;
	localparam logic [1:0] LEVEL_DOWN   = 2'd2;

	localparam logic [7:0] CH_GREEK    = 8'h5B; // [
	localparam logic [7:0] CH_LATIN    = 8'h5D; // ]
	localparam logic [7:0] CH_SPECIAL  = 8'h22; // "
	localparam logic [7:0] CH_LATIN2   = 8'h23; // #
	localparam logic [7:0] CH_NORMAL   = 8'h21; // !
	localparam logic [7:0] CH_UP       = 8'h5E; // ^
	localparam logic [7:0] CH_DOWN     = 8'h3F; // ?
	localparam logic [7:0] CH_BACK     = 8'h26; // &
	localparam logic [7:0] CH_BAR      = 8'h7C; // |

	function automatic logic [7:0] special_map(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			8'h42:   r = 8'h7C; // B
			8'h44:   r = 8'h24; // D
			8'h45:   r = 8'h21; // E
			8'h46:   r = 8'h23; // F
			8'h47:   r = 8'h3E; // G
			8'h48:   r = 8'h3F; // H
			8'h4A:   r = 8'h3A; // J
			8'h4B:   r = 8'h3B; // K
			8'h4C:   r = 8'h3C; // L
			8'h4D:   r = 8'h5B; // M
			8'h4E:   r = 8'h5D; // N
			8'h57:   r = 8'h26; // W
			8'h59:   r = 8'h25; // Y
			default: r = c;
		endcase
		return r;
	endfunction

	logic [1:0] font_q;
	logic [1:0] level_q;
	logic       back_q;
	logic       bar_q;
	logic [1:0] font_d;
	logic [1:0] level_d;
	logic       back_d;
	logic       bar_d;
	logic       is_ctrl;

	assign accept = push && !op_full;

	always_comb begin
		font_d  = font_q;
		level_d = level_q;
		back_d  = back_q;
		bar_d   = bar_q;
		is_ctrl = 1'b1;
		case (item.char_in)
			CH_GREEK:   font_d  = FONT_GREEK;
			CH_LATIN:   font_d  = FONT_LATIN;
			CH_SPECIAL: font_d  = FONT_SPECIAL;
			CH_LATIN2:  font_d  = FONT_LATIN;
			CH_NORMAL:  level_d = LEVEL_NORMAL;
			CH_UP:      level_d = LEVEL_UP;
			CH_DOWN:    level_d = LEVEL_DOWN;
			CH_BACK:    back_d  = 1'b1;
			CH_BAR:     bar_d   = 1'b1;
			default:    is_ctrl = 1'b0;
		endcase

		op.is_glyph    = !is_ctrl;
		op.last        = item.last_in;
		op.glyph.bar   = bar_q;
		op.glyph.back  = back_q;
		op.glyph.level = level_q;
		if (font_q == FONT_SPECIAL) begin
			op.glyph.code = special_map(item.char_in);
			op.glyph.font = 1'b0;
		end else begin
			op.glyph.code = item.char_in;
			op.glyph.font = (font_q == FONT_GREEK);
		end
		if (!is_ctrl) begin
			back_d = 1'b0;
			bar_d  = 1'b0;
		end

		// Control bytes only reach the back part when they close a string.
		op_push = accept && (!is_ctrl || item.last_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_q  <= FONT_LATIN;
			level_q <= LEVEL_NORMAL;
			back_q  <= 1'b0;
			bar_q   <= 1'b0;
		end else if (accept) begin
			if (item.last_in) begin
				font_q  <= FONT_LATIN;
				level_q <= LEVEL_NORMAL;
				back_q  <= 1'b0;
				bar_q   <= 1'b0;
			end else begin
				font_q  <= font_d;
				level_q <= level_d;
				back_q  <= back_d;
				bar_q   <= bar_d;
			end
		end
	end

endmodule

>>> rtl/core/etad_back.sv
module etad_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	input  etad_pkg::op_t  op,
	input  logic           out_full,
	output logic           op_pop,
	output logic           out_push,
	output etad_pkg::out_t out_data
);
	import etad_pkg::*;

	function automatic out_t make_result(input glyph_t g, input logic end_flag);
		out_t r;
		r.glyph_code  = g.code;
		r.glyph_font  = g.font;
		r.glyph_level = g.level;
		r.glyph_back  = g.back;
		r.glyph_bar   = g.bar;
		r.line_end    = end_flag;
		return r;
	endfunction

	glyph_t held_q;
	logic   held_valid_q;
	logic   flush_q;

	always_comb begin
		op_pop   = 1'b0;
		out_push = 1'b0;
		out_data = make_result(held_q, 1'b0);
		if (!out_full) begin
			if (flush_q) begin
				// Second result of a glyph that closed a string.
				out_push = 1'b1;
				out_data = make_result(held_q, 1'b1);
			end else if (op_valid) begin
				op_pop = 1'b1;
				if (op.is_glyph) begin
					if (held_valid_q) begin
						out_push = 1'b1;
						out_data = make_result(held_q, 1'b0);
					end else if (op.last) begin
						out_push = 1'b1;
						out_data = make_result(op.glyph, 1'b1);
					end
				end else if (op.last && held_valid_q) begin
					out_push = 1'b1;
					out_data = make_result(held_q, 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop && op.is_glyph) begin
			held_q <= op.glyph;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			flush_q      <= 1'b0;
		end else if (flush_q && !out_full) begin
			held_valid_q <= 1'b0;
			flush_q      <= 1'b0;
		end else if (op_pop) begin
			if (op.is_glyph) begin
				held_valid_q <= !op.last || held_valid_q;
				flush_q      <= op.last && held_valid_q;
			end else if (op.last) begin
				held_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/escaped_text_attribute_decoder_unit.sv
// Decodes a markup string one byte per transaction into glyphs with font,
// script level, backspace and overbar attributes. The input side takes one
// byte every cycle while the operation queue between the decoder and the
// glyph stage has room. Each glyph is held back until the next glyph or the
// end of the string arrives, so a glyph's result appears one glyph later.
// With both queues idle, the byte that releases a result passes through the
// operation queue and the glyph stage, and the result is then written to the
// result queue and shows on the result ports. When the last byte of a string
// is a glyph that follows a held glyph, the glyph stage writes two results,
// one per cycle while the result queue has room, and takes no new operation
// until the line_end result is written. Control bytes produce no result, and
// all decoder state returns to its reset values after the byte flagged as last.
module escaped_text_attribute_decoder_unit #(
	parameter int OP_DEPTH  = etad_pkg::OP_DEPTH_DEF,
	parameter int OUT_DEPTH = etad_pkg::OUT_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  etad_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output etad_pkg::out_t result
);
	import etad_pkg::*;

	logic accept;
	logic op_push;
	op_t  op_in;
	op_t  op_out;
	logic op_full;
	logic op_empty;
	logic op_pop;
	logic out_push;
	out_t out_data;
	logic out_full;

	assign full = op_full;

	etad_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.op_full (op_full),
		.accept  (accept),
		.op_push (op_push),
		.op      (op_in)
	);

	etad_fifo #(
		.T     (op_t),
		.DEPTH (OP_DEPTH)
	) u_op_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (op_push && accept),
		.wdata  (op_in),
		.rd     (op_pop),
		.rdata  (op_out),
		.full   (op_full),
		.empty  (op_empty)
	);

	etad_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (!op_empty),
		.op       (op_out),
		.out_full (out_full),
		.op_pop   (op_pop),
		.out_push (out_push),
		.out_data (out_data)
	);

	etad_fifo #(
		.T     (out_t),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_push),
		.wdata  (out_data),
		.rd     (pop),
		.rdata  (result),
		.full   (out_full),
		.empty  (empty)
	);

endmodule

>>> rtl/core/etad_checker.sv
`include "escaped_text_attribute_decoder_unit_defines.svh"

module etad_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           push,
	input logic           full,
	input logic           empty,
	input logic           pop,
	input etad_pkg::out_t result
);
	import etad_pkg::*;

	// The level code for three is never produced.
	`ETAD_ASSERT_NOW(a_level_range, clk, arst_n, !empty, result.glyph_level != 2'd3)

	// A waiting result that is not taken stays on the ports unchanged.
	`ETAD_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(result))

	// Reset leaves the result side empty and the input side open.
	`ETAD_ASSERT_NEXT_ALWAYS(a_reset, clk, !arst_n, empty && !full)

	// The input side can only fill up through an accepted transaction.
	`ETAD_ASSERT_NEXT(a_full_needs_push, clk, arst_n, !full && !push, !full)

endmodule

bind escaped_text_attribute_decoder_unit etad_checker u_etad_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
